// File: rtl/spectral_band_tremor_classifier_defines.svh
// Assertion macros shared by the classifier RTL.
`ifndef SPECTRAL_BAND_TREMOR_CLASSIFIER_DEFINES_SVH
`define SPECTRAL_BAND_TREMOR_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SBTC_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SBTC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sbtc_pkg.sv
// Shared constants, types and tables of the spectral band classifier.
package sbtc_pkg;

   localparam int SBTC_BINS        = 32;
   localparam int SBTC_HALF_WINDOW = 2;

   localparam int MAG_W      = 16;
   localparam int BAND_W     = 5;
   localparam int ENERGY_W   = 37;
   localparam int SQ_W       = 32;
   localparam int RATIO_W    = 9;
   localparam int LABEL_W    = 2;
   localparam int INTENS_W   = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 37;

   // Reciprocal scaling for the small window divisor.
   localparam int DIV_SHIFT = 20;
   localparam int RECIP_W   = 21;

   // Quotient bits produced by the ratio divider, one per cycle.
   localparam int DIV_STEPS = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_TREMOR_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TREMOR_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DYSK_LOW     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DYSK_HIGH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_FLOOR  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ENERGY   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTH_RATIO   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_RATIO = 3'd7;

   localparam logic [BAND_W-1:0]   RST_TREMOR_LOW   = 5'd10;
   localparam logic [BAND_W-1:0]   RST_TREMOR_HIGH  = 5'd15;
   localparam logic [BAND_W-1:0]   RST_DYSK_LOW     = 5'd16;
   localparam logic [BAND_W-1:0]   RST_DYSK_HIGH    = 5'd21;
   localparam logic [MAG_W-1:0]    RST_NOISE_FLOOR  = 16'd77;
   localparam logic [ENERGY_W-1:0] RST_MIN_ENERGY   = 37'd3276800;
   localparam logic [RATIO_W-1:0]  RST_BOTH_RATIO   = 9'd41;
   localparam logic [RATIO_W-1:0]  RST_SINGLE_RATIO = 9'd84;

   localparam logic [LABEL_W-1:0] LABEL_NORMAL = 2'd0;
   localparam logic [LABEL_W-1:0] LABEL_BOTH   = 2'd1;
   localparam logic [LABEL_W-1:0] LABEL_TREMOR = 2'd2;
   localparam logic [LABEL_W-1:0] LABEL_DYSK   = 2'd3;

   localparam logic [INTENS_W-1:0] NORMAL_INTENSITY = 9'd26;
   localparam logic [INTENS_W-1:0] INTENSITY_CAP    = 9'd307;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // floor(2^20 / d) for every window size that can occur.
   function automatic logic [RECIP_W-1:0] sbtc_recip(input logic [3:0] d);
      logic [RECIP_W-1:0] r;
      unique case (d)
         4'd1:    r = 21'd1048576;
         4'd2:    r = 21'd524288;
         4'd3:    r = 21'd349525;
         4'd4:    r = 21'd262144;
         4'd5:    r = 21'd209715;
         4'd6:    r = 21'd174762;
         4'd7:    r = 21'd149796;
         4'd8:    r = 21'd131072;
         4'd9:    r = 21'd116508;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/sbtc_div.sv
// Bit-serial divider forming the Q8 ratio of a band energy to the total energy.
module sbtc_div import sbtc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ENERGY_W-1:0] band,
   input  logic [ENERGY_W-1:0] total,
   output div_stat_type        stat,
   output logic [RATIO_W-1:0]  quotient
);

   localparam int                STEP_W    = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

   logic                run_ff;
   logic                done_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [ENERGY_W:0]   rem_ff;
   logic [ENERGY_W-1:0] den_ff;
   logic [RATIO_W-1:0]  q_ff;
   logic                zero_ff;

   logic [ENERGY_W:0]   diff;
   logic                ge;
   logic [ENERGY_W:0]   rem_sel;

   // The band never exceeds the total, so the first step starts from the band itself
   // and the quotient fits in nine bits.
   always_comb begin
      diff    = rem_ff - {1'b0, den_ff};
      ge      = rem_ff >= {1'b0, den_ff};
      rem_sel = ge ? diff : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= run_ff && (step_ff == STEP_LAST);
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= {1'b0, band};
         den_ff  <= total;
         zero_ff <= (total == '0);
      end else if (run_ff) begin
         rem_ff <= {rem_sel[ENERGY_W-1:0], 1'b0};
         q_ff   <= {q_ff[RATIO_W-2:0], ge};
      end
   end

   assign stat.busy = run_ff;
   assign stat.done = done_ff;
   assign quotient  = zero_ff ? '0 : q_ff;

endmodule

// File: rtl/spectral_band_tremor_classifier.sv
// Spectral band classifier: stores a frame of bins and labels it by band energy ratios.
//
// Requests: one bin magnitude (unsigned Q8.8) per request, taken at a rising edge with
// start high and busy low. Bins of a frame arrive in index order, one per cycle at most.
// After the BINS-th bin, busy rises while the frame is classified, and exactly one
// response (label and Q8 intensity) is shown on the rsp_ ports for a single cycle,
// marked by rsp_valid. The receiver cannot stall; the response is simply presented.
// From the last bin to the response, the frame takes one pass over the bin memory
// through its single read port (one bin per cycle), a five-stage smoothing and
// squaring pipeline to drain, and two runs of the shared nine-step ratio divider.
// Busy falls in the cycle the response appears, so the next frame may start at once.
// Configuration registers are written over the csr_ channel, which is always ready,
// and must only be written while the block is idle.
// Reset clears the bin count, the band energies and the registers to their defaults;
// the bin memory itself is not cleared, as every frame rewrites it before reading.
`include "spectral_band_tremor_classifier_defines.svh"

module spectral_band_tremor_classifier import sbtc_pkg::*; #(
   parameter int BINS        = SBTC_BINS,
   parameter int HALF_WINDOW = SBTC_HALF_WINDOW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [MAG_W-1:0]      req_bin_magnitude,
   output logic                  rsp_valid,
   output logic [LABEL_W-1:0]    rsp_label,
   output logic [INTENS_W-1:0]   rsp_intensity,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W  = $clog2(BINS);
   localparam int WALK_W = $clog2(BINS + HALF_WINDOW);
   localparam int WIN    = 2 * HALF_WINDOW + 1;
   localparam int CNT_W  = $clog2(WIN + 1);
   localparam int SUM_W  = MAG_W + $clog2(WIN);
   localparam int CMP_W  = (IDX_W > BAND_W) ? IDX_W : BAND_W;
   localparam int PROD_W = SUM_W + RECIP_W;

   localparam logic [IDX_W-1:0]  BIN_LAST  = IDX_W'(BINS - 1);
   localparam logic [WALK_W-1:0] BIN_END   = WALK_W'(BINS);
   localparam logic [WALK_W-1:0] WALK_LAST = WALK_W'(BINS + HALF_WINDOW - 1);
   localparam logic [WALK_W-1:0] FIRST_CTR = WALK_W'(HALF_WINDOW + 1);
   localparam logic [WALK_W-1:0] HALF_OFS  = WALK_W'(HALF_WINDOW);

   typedef enum logic [4:0] {
      ST_LOAD   = 5'b00001,
      ST_WALK   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_DIV_TR = 5'b01000,
      ST_DIV_DY = 5'b10000
   } state_type;

   function automatic logic [ENERGY_W-1:0] sat_add(input logic [ENERGY_W-1:0] a,
                                                   input logic [SQ_W-1:0]     b);
      logic [ENERGY_W:0] s;
      s = {1'b0, a} + (ENERGY_W + 1)'(b);
      return s[ENERGY_W] ? '1 : s[ENERGY_W-1:0];
   endfunction

   // Configuration registers.
   logic [BAND_W-1:0]   tremor_low_ff, tremor_high_ff, dysk_low_ff, dysk_high_ff;
   logic [MAG_W-1:0]    noise_floor_ff;
   logic [ENERGY_W-1:0] min_energy_ff;
   logic [RATIO_W-1:0]  both_ratio_ff, single_ratio_ff;

   // Control.
   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    bin_count_ff, bin_count_in;
   logic [WALK_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic                req_accept;
   logic                walk_init;
   logic                pipe_busy;

   // Bin memory.
   logic [MAG_W-1:0]    bin_mem [BINS];
   logic [MAG_W-1:0]    rd_data_ff;
   logic                rd_real;
   logic [IDX_W-1:0]    rd_addr;

   // Window and pipeline.
   logic                feed_ff, feed_real_ff, feed_emit_ff;
   logic [IDX_W-1:0]    feed_idx_ff;
   logic [MAG_W-1:0]    win_ff [WIN];
   logic [WIN-1:0]      win_v_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                s1_v_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic                s2_v_ff;
   logic [PROD_W-1:0]   s2_prod_ff;
   logic [SUM_W-1:0]    s2_sum_ff;
   logic [CNT_W-1:0]    s2_cnt_ff;
   logic [IDX_W-1:0]    s2_idx_ff;
   logic [MAG_W-1:0]    s2_q0;
   logic [SUM_W-1:0]    s2_qd;
   logic [SUM_W-1:0]    s2_rem;
   logic [MAG_W-1:0]    s2_mag;
   logic                s3_v_ff;
   logic [MAG_W-1:0]    s3_mag_ff;
   logic [IDX_W-1:0]    s3_idx_ff;
   logic                s3_keep;
   logic                s4_v_ff;
   logic [SQ_W-1:0]     s4_energy_ff;
   logic [IDX_W-1:0]    s4_idx_ff;
   logic [CMP_W-1:0]    s4_idx_c;
   logic                s4_in_tr, s4_in_dy;

   // Energies, ratios and response.
   logic [ENERGY_W-1:0] total_energy_ff, tremor_energy_ff, dysk_energy_ff;
   logic                div_start;
   logic [ENERGY_W-1:0] div_band;
   div_stat_type        div_stat;
   logic [RATIO_W-1:0]  div_q;
   logic [RATIO_W-1:0]  tr_ratio_ff, tr_ratio_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LABEL_W-1:0]  rsp_label_ff, label_in;
   logic [INTENS_W-1:0] rsp_intensity_ff, inten_in;
   logic [RATIO_W-1:0]  inten_raw;

   assign busy       = (state_ff != ST_LOAD);
   assign req_accept = start && !busy;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tremor_low_ff   <= RST_TREMOR_LOW;
         tremor_high_ff  <= RST_TREMOR_HIGH;
         dysk_low_ff     <= RST_DYSK_LOW;
         dysk_high_ff    <= RST_DYSK_HIGH;
         noise_floor_ff  <= RST_NOISE_FLOOR;
         min_energy_ff   <= RST_MIN_ENERGY;
         both_ratio_ff   <= RST_BOTH_RATIO;
         single_ratio_ff <= RST_SINGLE_RATIO;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TREMOR_LOW:   tremor_low_ff   <= csr_wdata[BAND_W-1:0];
            CSR_TREMOR_HIGH:  tremor_high_ff  <= csr_wdata[BAND_W-1:0];
            CSR_DYSK_LOW:     dysk_low_ff     <= csr_wdata[BAND_W-1:0];
            CSR_DYSK_HIGH:    dysk_high_ff    <= csr_wdata[BAND_W-1:0];
            CSR_NOISE_FLOOR:  noise_floor_ff  <= csr_wdata[MAG_W-1:0];
            CSR_MIN_ENERGY:   min_energy_ff   <= csr_wdata[ENERGY_W-1:0];
            CSR_BOTH_RATIO:   both_ratio_ff   <= csr_wdata[RATIO_W-1:0];
            CSR_SINGLE_RATIO: single_ratio_ff <= csr_wdata[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      bin_count_in = bin_count_ff;
      rd_cnt_in    = rd_cnt_ff;
      walk_init    = 1'b0;
      div_start    = 1'b0;
      div_band     = tremor_energy_ff;
      tr_ratio_in  = tr_ratio_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (bin_count_ff == BIN_LAST) begin
                  bin_count_in = '0;
                  rd_cnt_in    = '0;
                  walk_init    = 1'b1;
                  state_in     = ST_WALK;
               end else begin
                  bin_count_in = bin_count_ff + 1'b1;
               end
            end
         end
         ST_WALK: begin
            rd_cnt_in = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff == WALK_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               div_start = 1'b1;
               state_in  = ST_DIV_TR;
            end
         end
         ST_DIV_TR: begin
            if (div_stat.done) begin
               tr_ratio_in = div_q;
               div_start   = 1'b1;
               div_band    = dysk_energy_ff;
               state_in    = ST_DIV_DY;
            end
         end
         ST_DIV_DY: begin
            if (div_stat.done) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         bin_count_ff <= '0;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bin_count_ff <= bin_count_in;
         rd_cnt_ff    <= rd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Past the last bin the walk feeds empty slots to flush the window.
   assign rd_real = (rd_cnt_ff < BIN_END);
   assign rd_addr = rd_real ? rd_cnt_ff[IDX_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         bin_mem[bin_count_ff] <= req_bin_magnitude;
      end
      rd_data_ff <= bin_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feed_ff <= 1'b0;
      end else begin
         feed_ff <= (state_ff == ST_WALK);
      end
      feed_real_ff <= rd_real;
      feed_emit_ff <= (rd_cnt_ff >= FIRST_CTR);
      feed_idx_ff  <= IDX_W'(rd_cnt_ff - HALF_OFS);
   end

   // Running window sum: add the entering bin, drop the one leaving.
   always_comb begin
      sum_in = sum_ff + (feed_real_ff ? SUM_W'(rd_data_ff) : '0)
               - (win_v_ff[WIN-1] ? SUM_W'(win_ff[WIN-1]) : '0);
      cnt_in = cnt_ff + CNT_W'(feed_real_ff) - CNT_W'(win_v_ff[WIN-1]);
   end

   always_ff @(posedge clock) begin
      if (reset || walk_init) begin
         win_v_ff <= '0;
         sum_ff   <= '0;
         cnt_ff   <= '0;
      end else if (feed_ff) begin
         win_v_ff <= {win_v_ff[WIN-2:0], feed_real_ff};
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (feed_ff) begin
         win_ff[0] <= rd_data_ff;
         for (int k = 1; k < WIN; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
   end

   // Division by the neighbour count: reciprocal estimate, then one correction step.
   always_comb begin
      s2_q0  = s2_prod_ff[DIV_SHIFT +: MAG_W];
      s2_qd  = SUM_W'(SUM_W'(s2_q0) * SUM_W'(s2_cnt_ff));
      s2_rem = s2_sum_ff - s2_qd;
      s2_mag = s2_q0 + MAG_W'(s2_rem >= SUM_W'(s2_cnt_ff));
   end

   assign s3_keep = (s3_mag_ff >= noise_floor_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= feed_ff && feed_emit_ff;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff && s3_keep;
      end
      s1_idx_ff    <= feed_idx_ff;
      s2_prod_ff   <= PROD_W'(PROD_W'(sum_ff) * PROD_W'(sbtc_recip(4'(cnt_ff))));
      s2_sum_ff    <= sum_ff;
      s2_cnt_ff    <= cnt_ff;
      s2_idx_ff    <= s1_idx_ff;
      s3_mag_ff    <= s2_mag;
      s3_idx_ff    <= s2_idx_ff;
      s4_energy_ff <= SQ_W'(s3_mag_ff) * SQ_W'(s3_mag_ff);
      s4_idx_ff    <= s3_idx_ff;
   end

   assign pipe_busy = feed_ff | s1_v_ff | s2_v_ff | s3_v_ff | s4_v_ff;

   // A bin inside both bands is counted as tremor only.
   always_comb begin
      s4_idx_c = CMP_W'(s4_idx_ff);
      s4_in_tr = (s4_idx_c >= CMP_W'(tremor_low_ff)) && (s4_idx_c <= CMP_W'(tremor_high_ff));
      s4_in_dy = (s4_idx_c >= CMP_W'(dysk_low_ff)) && (s4_idx_c <= CMP_W'(dysk_high_ff));
   end

   always_ff @(posedge clock) begin
      if (reset || walk_init) begin
         total_energy_ff  <= '0;
         tremor_energy_ff <= '0;
         dysk_energy_ff   <= '0;
      end else if (s4_v_ff) begin
         total_energy_ff <= sat_add(total_energy_ff, s4_energy_ff);
         if (s4_in_tr) begin
            tremor_energy_ff <= sat_add(tremor_energy_ff, s4_energy_ff);
         end else if (s4_in_dy) begin
            dysk_energy_ff <= sat_add(dysk_energy_ff, s4_energy_ff);
         end
      end
   end

   sbtc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .band     (div_band),
      .total    (total_energy_ff),
      .stat     (div_stat),
      .quotient (div_q)
   );

   // The dyskinesia ratio is taken straight from the divider in its done cycle.
   always_comb begin
      label_in  = LABEL_NORMAL;
      inten_raw = RATIO_W'(NORMAL_INTENSITY);
      if (total_energy_ff < min_energy_ff) begin
         label_in  = LABEL_NORMAL;
         inten_raw = RATIO_W'(NORMAL_INTENSITY);
      end else if ((tr_ratio_ff >= both_ratio_ff) && (div_q >= both_ratio_ff)) begin
         label_in  = LABEL_BOTH;
         inten_raw = (tr_ratio_ff > div_q) ? tr_ratio_ff : div_q;
      end else if (tr_ratio_ff >= single_ratio_ff) begin
         label_in  = LABEL_TREMOR;
         inten_raw = tr_ratio_ff;
      end else if (div_q >= single_ratio_ff) begin
         label_in  = LABEL_DYSK;
         inten_raw = div_q;
      end
      inten_in = (INTENS_W'(inten_raw) > INTENSITY_CAP) ? INTENSITY_CAP : INTENS_W'(inten_raw);
   end

   always_ff @(posedge clock) begin
      tr_ratio_ff <= tr_ratio_in;
      if (rsp_valid_in) begin
         rsp_label_ff     <= label_in;
         rsp_intensity_ff <= inten_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_label     = rsp_label_ff;
   assign rsp_intensity = rsp_intensity_ff;

   `SBTC_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "response strobe held twice")
   `SBTC_ASSERT_IMPL(a_div_idle, state_ff == ST_LOAD, !div_stat.busy, "divider busy in load")
   `SBTC_ASSERT_IMPL(a_acc_walk, s4_v_ff, state_ff == ST_WALK || state_ff == ST_DRAIN, "late energy")
   `SBTC_ASSERT_NEXT(a_frame_end, req_accept && bin_count_ff == BIN_LAST, state_ff == ST_WALK, "no walk")

endmodule
